[sv/extent_free_list_allocator_top_defines.svh]
// ----------------------------------------------------------------------------
// extent_free_list_allocator_top_defines.svh
// Assertion macros used by the extent allocator top level.
// ----------------------------------------------------------------------------
`ifndef EXTENT_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define EXTENT_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define EFLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define EFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/efla_pkg.sv]
// ----------------------------------------------------------------------------
// efla_pkg
// Types and constants of the extent free-list allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package efla_pkg;

  // Total blocks managed; block 0 is never on the initial list
  localparam int unsigned NUM_BLOCKS = 1024;

  localparam int unsigned BLK_W     = 10;
  localparam int unsigned REC_DEPTH = 1 << BLK_W;

  // Initial free count, saturated to the count field
  localparam int unsigned INIT_COUNT_I =
      (NUM_BLOCKS - 1 > REC_DEPTH - 1) ? REC_DEPTH - 1 : NUM_BLOCKS - 1;
  localparam logic [BLK_W-1:0] INIT_COUNT = INIT_COUNT_I[BLK_W-1:0];

  // Block that holds the whole free run after reset
  localparam logic [BLK_W-1:0] FIRST_BLOCK = BLK_W'(1);

  // Request codes
  typedef enum logic {
    FUNC_ALLOC   = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  // Free extent record: run length, link to next run, link valid
  typedef struct packed {
    logic             link_valid;
    logic [BLK_W-1:0] link;
    logic [BLK_W-1:0] run;
  } rec_t;

  localparam rec_t INIT_REC = '{link_valid: 1'b0, link: '0, run: INIT_COUNT};

  // List head pointer
  typedef struct packed {
    logic             valid;
    logic [BLK_W-1:0] blk;
  } head_t;

  // Record memory access from the controller
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [BLK_W-1:0] addr;
    rec_t             wdata;
  } mem_req_t;

  // One result word
  typedef struct packed {
    logic             head_valid;
    logic [BLK_W-1:0] head_block;
    logic [BLK_W-1:0] free_count;
    logic             success;
    logic [BLK_W-1:0] granted_block;
  } result_t;

endpackage

`default_nettype wire

[sv/extent_free_list_allocator_top.sv]
// ----------------------------------------------------------------------------
// extent_free_list_allocator_top
// Block allocator over a linked list of free extents kept in a record memory.
// ----------------------------------------------------------------------------
// Each input word is one request and produces exactly one result word. A
// release writes its record in the cycle it is accepted. An allocate first
// reads the head record from the synchronous record memory, then writes
// back the shortened record or, for a single-block run, follows the link.
// One request is in flight at a time; the input is taken whenever the
// controller is idle and the result register is empty or being drained. No
// clearing pass is needed after reset: only the first block's initial record
// is tracked. Double releases are not checked; the free count saturates at 1023.
`timescale 1ns / 1ps
`default_nettype none

`include "extent_free_list_allocator_top_defines.svh"

module extent_free_list_allocator_top
  import efla_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [9:0] rel_block, [15:10] zero
  input  wire logic        s_tuser,   // [0] func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [9:0] granted_block, [10] success, [20:11] free_count,
  // [30:21] head_block, [31] head_valid
  output logic [31:0]      m_tdata
);

  mem_req_t mem_req;
  rec_t     mem_rdata;
  result_t  result;
  logic     in_fire;
  logic     out_stall;

  efla_rec_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  efla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .func      (func_t'(s_tuser)),
    .rel_block (s_tdata[BLK_W-1:0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  assign m_tdata = result;

  assign in_fire   = s_tvalid && s_tready;
  assign out_stall = m_tvalid && !m_tready;

  // No word is taken while a finished result is stalled
  `EFLA_ASSERT_NOW(a_no_accept_on_stall, in_fire, !out_stall, "input taken while result stalled")
  // A release shows its result in the next cycle
  `EFLA_ASSERT_NEXT(a_release_result, in_fire && s_tuser, m_tvalid, "release result missing")
  // An allocate holds off the input while its record is read, or fails at once
  `EFLA_ASSERT_NEXT(a_alloc_busy, in_fire && !s_tuser, !s_tready || m_tvalid, "allocate not held off")

endmodule

`default_nettype wire

[sv/efla_rec_mem.sv]
// ----------------------------------------------------------------------------
// efla_rec_mem
// Free extent record store: one synchronous port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efla_rec_mem
  import efla_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mem_req_t req,
  output rec_t          rdata
);

  rec_t       mem [REC_DEPTH];
  rec_t       rd_raw;
  logic       first_written;   // first block rewritten since reset
  logic       rd_init;         // last read hit the untouched first block

  // Write and read the record array
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_raw <= mem[req.addr];
    end
  end

  // Track the reset record of the first block
  always_ff @(posedge clk) begin
    if (rst) begin
      first_written <= 1'b0;
      rd_init       <= 1'b0;
    end else begin
      if (req.wr_en && req.addr == FIRST_BLOCK) begin
        first_written <= 1'b1;
      end
      if (req.rd_en) begin
        rd_init <= (req.addr == FIRST_BLOCK) && !first_written;
      end
    end
  end

  assign rdata = rd_init ? INIT_REC : rd_raw;

endmodule

`default_nettype wire

[sv/efla_ctrl.sv]
// ----------------------------------------------------------------------------
// efla_ctrl
// Request sequencer: list head, free count, record updates, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efla_ctrl
  import efla_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire func_t            func,
  input  wire logic [BLK_W-1:0] rel_block,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output result_t               result,
  output mem_req_t              mem_req,
  input  wire rec_t             mem_rdata
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_RDATA = 2'b10
  } state_t;

  state_t           state, state_next;
  head_t            head, head_next;
  logic [BLK_W-1:0] free_total, free_total_next;
  logic             load_res;
  result_t          res_next;
  logic             accept;
  logic             can_alloc;
  logic [BLK_W-1:0] nb;

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign can_alloc = (free_total != '0) && head.valid;
  assign nb        = head.blk + BLK_W'(1);

  // Decide the memory access, next head and count, and the result
  always_comb begin
    state_next      = state;
    head_next       = head;
    free_total_next = free_total;
    load_res        = 1'b0;
    mem_req         = '0;
    res_next        = '0;
    res_next.success = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (func == FUNC_RELEASE) begin
            // push a one-block record in front of the head
            mem_req.wr_en            = 1'b1;
            mem_req.addr             = rel_block;
            mem_req.wdata.link_valid = head.valid;
            mem_req.wdata.link       = head.blk;
            mem_req.wdata.run        = BLK_W'(1);
            head_next.valid          = 1'b1;
            head_next.blk            = rel_block;
            if (free_total != '1) begin
              free_total_next = free_total + BLK_W'(1);
            end
            load_res = 1'b1;
          end else if (can_alloc) begin
            // fetch the head record
            mem_req.rd_en = 1'b1;
            mem_req.addr  = head.blk;
            state_next    = S_RDATA;
          end else begin
            // empty list: fail and hold state
            res_next.success = 1'b0;
            load_res         = 1'b1;
          end
        end
      end
      S_RDATA: begin
        res_next.granted_block = head.blk;
        if (mem_rdata.run > BLK_W'(1)) begin
          // shorten the run and move the head one block up
          mem_req.wr_en            = 1'b1;
          mem_req.addr             = nb;
          mem_req.wdata.link_valid = mem_rdata.link_valid;
          mem_req.wdata.link       = mem_rdata.link;
          mem_req.wdata.run        = mem_rdata.run - BLK_W'(1);
          head_next.valid          = 1'b1;
          head_next.blk            = nb;
        end else begin
          // follow the link to the next run
          head_next.valid = mem_rdata.link_valid;
          head_next.blk   = mem_rdata.link_valid ? mem_rdata.link : '0;
        end
        free_total_next = free_total - BLK_W'(1);
        load_res        = 1'b1;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res_next.free_count = free_total_next;
    res_next.head_valid = head_next.valid;
    res_next.head_block = head_next.valid ? head_next.blk : '0;
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '{valid: 1'b1, blk: FIRST_BLOCK};
      free_total <= INIT_COUNT;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      free_total <= free_total_next;
      if (load_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result word
  always_ff @(posedge clk) begin
    if (load_res) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

[dv/tb_extent_free_list_allocator_top.sv]
// ----------------------------------------------------------------------------
// tb_extent_free_list_allocator_top
// Self-checking bench for the extent free-list allocator: a queue-fed driver
// pushes allocate and release words, a monitor predicts each result word on
// acceptance and checks the output stream in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_extent_free_list_allocator_top;
  import efla_pkg::*;

  // One pending request word, or a hold-off marker that waits for a drain
  typedef struct {
    bit               hold_off;
    func_t            func;
    logic [BLK_W-1:0] blk;
  } req_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [9:0] rel_block, [15:10] zero
  logic        s_tuser = 1'b0; // [0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [9:0] granted_block, [10] success, [20:11] free_count,
  // [30:21] head_block, [31] head_valid
  logic [31:0] m_tdata;

  extent_free_list_allocator_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  req_word_t   pending_reqs[$];
  result_t     expected_results[$];
  int unsigned total_reqs;
  int unsigned accepted_cnt;
  int unsigned error_cnt;
  logic        in_taken = 1'b0;

  // Shadow allocator state
  rec_t             shadow_recs[REC_DEPTH];
  head_t            shadow_head;
  logic [BLK_W-1:0] shadow_free;

  // Coverage tallies for the closing summary
  int unsigned n_grant, n_fail, n_release, n_saturate;

  // Work out the result word of one request and advance the shadow state
  function automatic result_t predict_request(func_t op, logic [BLK_W-1:0] blk);
    result_t          r;
    rec_t             cur;
    logic [BLK_W-1:0] nxt;
    r = '0;
    r.success = 1'b1;
    if (op == FUNC_ALLOC) begin
      if (shadow_free != '0 && shadow_head.valid) begin
        cur = shadow_recs[shadow_head.blk];
        r.granted_block = shadow_head.blk;
        if (cur.run > 1) begin
          // Shorten the run: the remainder starts one block higher
          nxt = shadow_head.blk + 1'b1;
          shadow_recs[nxt].link_valid = cur.link_valid;
          shadow_recs[nxt].link = cur.link;
          shadow_recs[nxt].run = cur.run - 1'b1;
          shadow_head.valid = 1'b1;
          shadow_head.blk = nxt;
        end else if (cur.link_valid) begin
          shadow_head.valid = 1'b1;
          shadow_head.blk = cur.link;
        end else begin
          shadow_head = '0;
        end
        shadow_free = shadow_free - 1'b1;
        n_grant++;
      end else begin
        r.success = 1'b0;
        n_fail++;
      end
    end else begin
      // Push a one-block run in front of the head, linked to the old head
      shadow_recs[blk].link_valid = shadow_head.valid;
      shadow_recs[blk].link = shadow_head.valid ? shadow_head.blk : '0;
      shadow_recs[blk].run = BLK_W'(1);
      shadow_head.valid = 1'b1;
      shadow_head.blk = blk;
      if (shadow_free != '1) shadow_free = shadow_free + 1'b1;
      else n_saturate++;
      n_release++;
    end
    r.free_count = shadow_free;
    r.head_valid = shadow_head.valid;
    r.head_block = shadow_head.valid ? shadow_head.blk : '0;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_cnt++;
    end
  endfunction

  // Idle percentage per side: sender light first, then receiver light, then none
  function automatic int unsigned idle_pct(bit rx_side);
    if (accepted_cnt < total_reqs / 3) return rx_side ? 49 : 6;
    if (accepted_cnt < 2 * total_reqs / 3) return rx_side ? 6 : 49;
    return 0;
  endfunction

  function automatic logic [BLK_W-1:0] pick_block();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return BLK_W'($urandom_range(0, REC_DEPTH - 1));
  endfunction

  function automatic void add_req(func_t op, logic [BLK_W-1:0] blk);
    req_word_t w;
    w.hold_off = 1'b0;
    w.func = op;
    w.blk = blk;
    pending_reqs.push_back(w);
    total_reqs++;
  endfunction

  function automatic void add_hold_off();
    req_word_t w;
    w.hold_off = 1'b1;
    w.func = FUNC_ALLOC;
    w.blk = '0;
    pending_reqs.push_back(w);
  endfunction

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Driver: present words and the ready at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
      if (!s_tvalid || in_taken) begin
        if (pending_reqs.size() != 0 && pending_reqs[0].hold_off) begin
          // Hold off until every outstanding result word is back
          if (expected_results.size() == 0) void'(pending_reqs.pop_front());
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          s_tvalid <= 1'b1;
          s_tuser  <= pending_reqs[0].func;
          s_tdata  <= {6'b0, pending_reqs[0].blk};
          void'(pending_reqs.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check the result word first, then predict the accepted request
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, m_tdata);
          error_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("granted_block", want.granted_block, got.granted_block);
          check_field("success", want.success, got.success);
          check_field("free_count", want.free_count, got.free_count);
          check_field("head_block", want.head_block, got.head_block);
          check_field("head_valid", want.head_valid, got.head_valid);
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_request(func_t'(s_tuser), s_tdata[BLK_W-1:0]));
        accepted_cnt++;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned wait_cnt;
    total_reqs = 0;
    accepted_cnt = 0;
    error_cnt = 0;
    n_grant = 0;
    n_fail = 0;
    n_release = 0;
    n_saturate = 0;
    for (int i = 0; i < REC_DEPTH; i++) shadow_recs[i] = '0;
    shadow_recs[FIRST_BLOCK] = INIT_REC;
    shadow_head.valid = 1'b1;
    shadow_head.blk = FIRST_BLOCK;
    shadow_free = INIT_COUNT;

    // Directed: releases at the count ceiling, field extremes, chain walking
    add_req(FUNC_RELEASE, '0);
    add_req(FUNC_RELEASE, '1);
    add_req(FUNC_ALLOC, '0);
    add_req(FUNC_ALLOC, '1);
    add_req(FUNC_ALLOC, BLK_W'(10'h2AA));
    add_req(FUNC_ALLOC, BLK_W'(10'h155));
    add_req(FUNC_RELEASE, BLK_W'(1));
    add_req(FUNC_RELEASE, '1);
    add_req(FUNC_ALLOC, pick_block());
    add_req(FUNC_ALLOC, pick_block());
    add_req(FUNC_ALLOC, pick_block());
    add_req(FUNC_RELEASE, BLK_W'(10'h2AA));
    add_req(FUNC_RELEASE, BLK_W'(10'h155));
    add_req(FUNC_ALLOC, pick_block());
    add_req(FUNC_ALLOC, pick_block());
    add_hold_off();

    // Drain the whole list through the shortened runs, then fail on empty
    for (int i = 0; i < 1040; i++) add_req(FUNC_ALLOC, pick_block());
    add_hold_off();

    // Double release that also hits the current head, then run dry again;
    // kept after the drain since it turns the list into a loop
    add_req(FUNC_RELEASE, BLK_W'(5));
    add_req(FUNC_RELEASE, BLK_W'(5));
    add_req(FUNC_ALLOC, pick_block());
    add_req(FUNC_ALLOC, pick_block());
    add_req(FUNC_ALLOC, pick_block());
    add_req(FUNC_ALLOC, pick_block());
    add_hold_off();

    // Mixed traffic: release-heavy, balanced, then allocate-heavy
    for (int i = 0; i < 790; i++) begin
      int unsigned rel_pct;
      rel_pct = (i < 260) ? 60 : (i < 530) ? 50 : 35;
      if ($urandom_range(0, 99) < rel_pct)
        add_req(FUNC_RELEASE, ($urandom_range(0, 7) == 0) ?
                BLK_W'($urandom_range(0, 15)) : pick_block());
      else
        add_req(FUNC_ALLOC, pick_block());
    end

    // Reset
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait for the last request word to be taken
    do @(posedge clk); while (pending_reqs.size() != 0 || s_tvalid);

    // Wait for the outstanding results, bounded
    wait_cnt = 0;
    while (expected_results.size() != 0 && wait_cnt < 5000) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (expected_results.size() != 0) begin
      $display("%0t: %0d result words never arrived, expected head granted_block %0d",
               $time, expected_results.size(), expected_results[0].granted_block);
      error_cnt++;
    end
    repeat (10) @(posedge clk);

    $display("Ran %0d requests: %0d grants, %0d failed allocates, %0d releases",
             accepted_cnt, n_grant, n_fail, n_release);
    $display("Releases at the count ceiling: %0d; list drained and looped by double release",
             n_saturate);
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("%0t: watchdog expired", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/efla_pkg.sv
sv/efla_rec_mem.sv
sv/efla_ctrl.sv
sv/extent_free_list_allocator_top.sv
dv/tb_extent_free_list_allocator_top.sv
